/* hw/rtl/alsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Anti-aliased line stepper package
// Shared constants, register indexes and the command flag type that travels
// from the front end to the back end through the command queue.
// ----------------------------------------------------------------------------
package alsp_pkg;

   // Default coordinate and fraction widths.
   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;

   // Window registers.
   localparam int WIN_BITS = 13;
   localparam logic [WIN_BITS-1:0] WIN_WIDTH_RST  = 13'd1024;
   localparam logic [WIN_BITS-1:0] WIN_HEIGHT_RST = 13'd768;

   // Configuration register indexes.
   localparam int CSR_IDX_BITS = 1;
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WINDOW_WIDTH  = 1'b0,
      CSR_WINDOW_HEIGHT = 1'b1
   } csr_index_type;

   // Input item kinds.
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   // Command queue depth, a power of two.
   localparam int QUEUE_DEPTH = 2;

   // Classification of one command.
   typedef struct packed {
      logic is_step;
      logic reject;
      logic steep;
      logic swap;
      logic dy_neg;
      logic dx_zero;
   } cmd_flags_type;

   localparam int CMD_FLAG_BITS    = $bits(cmd_flags_type);
   // Coordinate fields of a command: column start, column end, minor start,
   // major distance and minor distance.
   localparam int CMD_COORD_FIELDS = 5;

endpackage
`default_nettype wire

/* hw/rtl/alsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Anti-aliased line stepper channels
// Request and response channels with a valid/ready transfer handshake.
// ----------------------------------------------------------------------------
interface alsp_req_if
   import alsp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (
      output valid, kind, start_x, start_y, end_x, end_y,
      input  ready
   );
   modport sink (
      input  valid, kind, start_x, start_y, end_x, end_y,
      output ready
   );
endinterface

interface alsp_rsp_if
   import alsp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         accepted;
   logic                         pixel_valid;
   logic signed [COORD_BITS-1:0] first_x;
   logic signed [COORD_BITS-1:0] first_y;
   logic signed [COORD_BITS-1:0] second_x;
   logic signed [COORD_BITS-1:0] second_y;
   logic [FRAC_BITS:0]           weight_first;
   logic [FRAC_BITS-1:0]         weight_second;
   logic                         reversed;
   logic                         last;

   modport source (
      output valid, accepted, pixel_valid, first_x, first_y, second_x, second_y,
             weight_first, weight_second, reversed, last,
      input  ready
   );
   modport sink (
      input  valid, accepted, pixel_valid, first_x, first_y, second_x, second_y,
             weight_first, weight_second, reversed, last,
      output ready
   );
endinterface
`default_nettype wire

/* hw/rtl/alsp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line stepper front end
// Holds the window registers, takes request transfers and classifies them:
// window rejection, steepness, axis swap and endpoint order.
// ----------------------------------------------------------------------------
module alsp_front
   import alsp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]                csr_index,
   input  wire logic [WIN_BITS-1:0]                    csr_wdata,
   alsp_req_if.sink                                    req_ch,
   output logic                                        push_valid,
   input  wire logic                                   push_ready,
   output cmd_flags_type                               push_flags,
   output logic [CMD_COORD_FIELDS*COORD_BITS-1:0]      push_data
);

   localparam int CB    = COORD_BITS;
   localparam int CMP_W = (CB > WIN_BITS) ? CB : WIN_BITS;

   // True when a coordinate is negative or at or beyond its window limit.
   function automatic logic off_window(logic signed [CB-1:0] c, logic [WIN_BITS-1:0] lim);
      logic [CMP_W-1:0] c_ext;
      logic [CMP_W-1:0] lim_ext;
      c_ext   = CMP_W'($unsigned(c));
      lim_ext = CMP_W'(lim);
      return c[CB-1] || (c_ext >= lim_ext);
   endfunction

   logic [WIN_BITS-1:0]  x_limit_ff;
   logic [WIN_BITS-1:0]  y_limit_ff;

   logic                 accept;
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic                 s1_step_ff;
   logic                 s1_reject_ff;
   logic signed [CB-1:0] s1_sx_ff;
   logic signed [CB-1:0] s1_sy_ff;
   logic signed [CB-1:0] s1_ex_ff;
   logic signed [CB-1:0] s1_ey_ff;
   logic [CB:0]          s1_dx_ff;
   logic [CB:0]          s1_dy_ff;
   logic [CB:0]          diff_x;
   logic [CB:0]          diff_y;

   logic [CB-1:0]        abs_x;
   logic [CB-1:0]        abs_y;
   logic                 steep;
   logic                 swap;
   logic                 min_neg;
   logic signed [CB-1:0] maj_s;
   logic signed [CB-1:0] maj_e;
   logic signed [CB-1:0] min_s;
   logic signed [CB-1:0] min_e;
   logic signed [CB-1:0] col_start;
   logic signed [CB-1:0] col_end;
   logic signed [CB-1:0] minor_start;
   logic [CB-1:0]        dist_maj;
   logic [CB-1:0]        dist_min;

   // Window registers, written at any configuration transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff <= WIN_WIDTH_RST;
         y_limit_ff <= WIN_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_WIDTH:  x_limit_ff <= csr_wdata;
            CSR_WINDOW_HEIGHT: y_limit_ff <= csr_wdata;
         endcase
      end
   end

   // The first stage takes a transfer whenever it is empty or being drained.
   assign req_ch.ready = !s1_valid_ff || push_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign diff_x = {req_ch.end_x[CB-1], req_ch.end_x} - {req_ch.start_x[CB-1], req_ch.start_x};
   assign diff_y = {req_ch.end_y[CB-1], req_ch.end_y} - {req_ch.start_y[CB-1], req_ch.start_y};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   // First stage: endpoint differences and window rejection.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_step_ff   <= (req_ch.kind == KIND_STEP);
         s1_reject_ff <= off_window(req_ch.start_x, x_limit_ff) ||
                         off_window(req_ch.start_y, y_limit_ff) ?
                         (off_window(req_ch.end_x, x_limit_ff) ||
                          off_window(req_ch.end_y, y_limit_ff)) : 1'b0;
         s1_sx_ff     <= req_ch.start_x;
         s1_sy_ff     <= req_ch.start_y;
         s1_ex_ff     <= req_ch.end_x;
         s1_ey_ff     <= req_ch.end_y;
         s1_dx_ff     <= diff_x;
         s1_dy_ff     <= diff_y;
      end
   end

   // Second stage: magnitudes, steepness, axis swap and left-to-right order.
   always_comb begin
      abs_x = s1_dx_ff[CB] ? CB'(-s1_dx_ff) : CB'(s1_dx_ff);
      abs_y = s1_dy_ff[CB] ? CB'(-s1_dy_ff) : CB'(s1_dy_ff);
      steep = abs_y > abs_x;

      maj_s    = steep ? s1_sy_ff : s1_sx_ff;
      maj_e    = steep ? s1_ey_ff : s1_ex_ff;
      min_s    = steep ? s1_sx_ff : s1_sy_ff;
      min_e    = steep ? s1_ex_ff : s1_ey_ff;
      swap     = steep ? s1_dy_ff[CB] : s1_dx_ff[CB];
      min_neg  = steep ? s1_dx_ff[CB] : s1_dy_ff[CB];
      dist_maj = steep ? abs_y : abs_x;
      dist_min = steep ? abs_x : abs_y;

      col_start   = swap ? maj_e : maj_s;
      col_end     = swap ? maj_s : maj_e;
      minor_start = swap ? min_e : min_s;

      push_flags.is_step = s1_step_ff;
      push_flags.reject  = s1_reject_ff;
      push_flags.steep   = steep;
      push_flags.swap    = swap;
      // Reordering the endpoints flips the sign of the minor distance.
      push_flags.dy_neg  = min_neg ^ swap;
      push_flags.dx_zero = (dist_maj == '0);
   end

   assign push_valid = s1_valid_ff;
   assign push_data  = {col_start, col_end, minor_start, dist_maj, dist_min};

endmodule
`default_nettype wire

/* hw/rtl/alsp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line stepper command queue
// A short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module alsp_queue
   import alsp_pkg::*;
#(
   parameter int WIDTH = CMD_FLAG_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // Pointers wrap on their own since the depth is a power of two.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/alsp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line stepper back end
// A start not rejected sets up the line and, if not a point, forms the slope
// with a restoring divider, one quotient bit per cycle; a step emits a column.
// ----------------------------------------------------------------------------
module alsp_back
   import alsp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   pop_valid,
   output logic                                        pop_ready,
   input  wire cmd_flags_type                          pop_flags,
   input  wire logic [CMD_COORD_FIELDS*COORD_BITS-1:0] pop_data,
   alsp_rsp_if.source                                  rsp_ch
);

   localparam int CB    = COORD_BITS;
   localparam int F     = FRAC_BITS;
   localparam int AW    = CB + F;
   localparam int SW    = F + 2;
   localparam int CNT_W = $clog2(F + 2);

   typedef enum logic {
      ST_RUN,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic                 accepted;
      logic                 pixel_valid;
      logic signed [CB-1:0] first_x;
      logic signed [CB-1:0] first_y;
      logic signed [CB-1:0] second_x;
      logic signed [CB-1:0] second_y;
      logic [F:0]           weight_first;
      logic [F-1:0]         weight_second;
      logic                 reversed;
      logic                 last;
   } rsp_type;

   state_type            state_ff, state_in;
   logic                 line_active_ff, line_active_in;
   logic                 steep_ff, steep_in;
   logic                 swap_ff, swap_in;
   logic signed [CB-1:0] col_now_ff, col_now_in;
   logic signed [CB-1:0] col_end_ff, col_end_in;
   logic [AW-1:0]        acc_ff, acc_in;
   logic [SW-1:0]        slope_ff, slope_in;
   logic [CB:0]          div_rem_ff, div_rem_in;
   logic [F:0]           div_quo_ff, div_quo_in;
   logic [CB-1:0]        div_dx_ff, div_dx_in;
   logic [CNT_W-1:0]     div_cnt_ff, div_cnt_in;
   logic                 div_neg_ff, div_neg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 out_free;
   logic signed [CB-1:0] cmd_col_start;
   logic signed [CB-1:0] cmd_col_end;
   logic signed [CB-1:0] cmd_minor;
   logic [CB-1:0]        cmd_dist_maj;
   logic [CB-1:0]        cmd_dist_min;

   logic signed [CB-1:0] ip;
   logic signed [CB-1:0] ip_next;
   logic [F-1:0]         frac;
   logic [F:0]           frac_inv;
   logic                 fin;
   logic                 div_ge;
   logic [CB:0]          div_sub;
   logic [SW-1:0]        quo_ext;

   // Command fields, packed by the front end.
   assign cmd_col_start = pop_data[5*CB-1 -: CB];
   assign cmd_col_end   = pop_data[4*CB-1 -: CB];
   assign cmd_minor     = pop_data[3*CB-1 -: CB];
   assign cmd_dist_maj  = pop_data[2*CB-1 -: CB];
   assign cmd_dist_min  = pop_data[CB-1:0];

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign pop_ready = (state_ff == ST_RUN) && out_free;

   // Column terms: floor of the accumulator and its fraction.
   assign ip       = acc_ff[AW-1:F];
   assign ip_next  = ip + 1'b1;
   assign frac     = acc_ff[F-1:0];
   assign frac_inv = {1'b1, {F{1'b0}}} - {1'b0, frac};
   assign fin      = col_now_ff >= col_end_ff;

   // One restoring divider step.
   assign div_ge  = div_rem_ff >= {1'b0, div_dx_ff};
   assign div_sub = div_ge ? (div_rem_ff - {1'b0, div_dx_ff}) : div_rem_ff;
   assign quo_ext = {1'b0, div_quo_ff};

   always_comb begin
      state_in       = state_ff;
      line_active_in = line_active_ff;
      steep_in       = steep_ff;
      swap_in        = swap_ff;
      col_now_in     = col_now_ff;
      col_end_in     = col_end_ff;
      acc_in         = acc_ff;
      slope_in       = slope_ff;
      div_rem_in     = div_rem_ff;
      div_quo_in     = div_quo_ff;
      div_dx_in      = div_dx_ff;
      div_cnt_in     = div_cnt_ff;
      div_neg_in     = div_neg_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;

      unique case (state_ff)
         ST_RUN: begin
            if (pop_valid && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               if (pop_flags.is_step) begin
                  // Emit one column of the running line.
                  if (line_active_ff) begin
                     rsp_in.pixel_valid   = 1'b1;
                     rsp_in.first_x       = steep_ff ? ip : col_now_ff;
                     rsp_in.first_y       = steep_ff ? col_now_ff : ip;
                     rsp_in.second_x      = steep_ff ? ip_next : col_now_ff;
                     rsp_in.second_y      = steep_ff ? col_now_ff : ip_next;
                     rsp_in.weight_first  = frac_inv;
                     rsp_in.weight_second = frac;
                     rsp_in.reversed      = swap_ff;
                     rsp_in.last          = fin;
                     if (fin) begin
                        line_active_in = 1'b0;
                     end else begin
                        col_now_in = col_now_ff + 1'b1;
                        acc_in     = acc_ff + {{(AW-SW){slope_ff[SW-1]}}, slope_ff};
                     end
                  end
               end else if (pop_flags.reject) begin
                  line_active_in = 1'b0;
                  swap_in        = 1'b0;
               end else begin
                  // Set up the new line; the slope follows.
                  line_active_in = 1'b1;
                  steep_in       = pop_flags.steep;
                  swap_in        = pop_flags.swap;
                  col_now_in     = cmd_col_start;
                  col_end_in     = cmd_col_end;
                  acc_in         = {cmd_minor, {F{1'b0}}};
                  if (pop_flags.dx_zero) begin
                     slope_in        = {2'b01, {F{1'b0}}};
                     rsp_in.accepted = 1'b1;
                     rsp_in.reversed = pop_flags.swap;
                  end else begin
                     rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
                     rsp_in       = rsp_ff;
                     div_rem_in   = {1'b0, cmd_dist_min};
                     div_quo_in   = '0;
                     div_dx_in    = cmd_dist_maj;
                     div_cnt_in   = CNT_W'(F + 1);
                     div_neg_in   = pop_flags.dy_neg;
                     state_in     = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_cnt_ff != '0) begin
               div_rem_in = {div_sub[CB-1:0], 1'b0};
               div_quo_in = {div_quo_ff[F-1:0], div_ge};
               div_cnt_in = div_cnt_ff - 1'b1;
            end else if (out_free) begin
               // Quotient done: apply the sign and answer the start.
               slope_in        = div_neg_ff ? (SW'(0) - quo_ext) : quo_ext;
               rsp_valid_in    = 1'b1;
               rsp_in          = '0;
               rsp_in.accepted = 1'b1;
               rsp_in.reversed = swap_ff;
               state_in        = ST_RUN;
            end
         end
      endcase
   end

   // State, line registers, divider and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_RUN;
         line_active_ff <= 1'b0;
         steep_ff       <= 1'b0;
         swap_ff        <= 1'b0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         line_active_ff <= line_active_in;
         steep_ff       <= steep_in;
         swap_ff        <= swap_in;
         div_cnt_ff     <= div_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      col_now_ff <= col_now_in;
      col_end_ff <= col_end_in;
      acc_ff     <= acc_in;
      slope_ff   <= slope_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_dx_ff  <= div_dx_in;
      div_neg_ff <= div_neg_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.accepted      = rsp_ff.accepted;
   assign rsp_ch.pixel_valid   = rsp_ff.pixel_valid;
   assign rsp_ch.first_x       = rsp_ff.first_x;
   assign rsp_ch.first_y       = rsp_ff.first_y;
   assign rsp_ch.second_x      = rsp_ff.second_x;
   assign rsp_ch.second_y      = rsp_ff.second_y;
   assign rsp_ch.weight_first  = rsp_ff.weight_first;
   assign rsp_ch.weight_second = rsp_ff.weight_second;
   assign rsp_ch.reversed      = rsp_ff.reversed;
   assign rsp_ch.last          = rsp_ff.last;

endmodule
`default_nettype wire

/* hw/rtl/antialiased_line_stepper_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Anti-aliased line stepper
// Wu-style line generator: a start sets up a line, each step emits one column
// of two neighboring pixels with their coverage weights.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake     Carries
//  req_ch    in         valid/ready   kind, start_x, start_y, end_x, end_y
//  rsp_ch    out        valid/ready   accepted, pixel_valid, pixel pair, weights,
//                                     reversed, last
//  csr_*     in         csr_we        csr_index, csr_wdata (window size)
//
// Step transfers stream at one per cycle while the response side is ready and
// no start is dividing: the back end then emits a column per cycle. A start
// holds the back end while the restoring divider forms the slope one quotient
// bit per cycle; a rejected or zero-length start skips the divider. A request
// is registered in the front end, the queue and the response register in turn.
// Reset is synchronous and needs no clearing pass.
// A two-entry command queue and the response register let either side stall.
// ----------------------------------------------------------------------------
module antialiased_line_stepper_top
   import alsp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [WIN_BITS-1:0]     csr_wdata,
   alsp_req_if.sink                     req_ch,
   alsp_rsp_if.source                   rsp_ch
);

   localparam int DATA_W = CMD_COORD_FIELDS * COORD_BITS;
   localparam int Q_W    = CMD_FLAG_BITS + DATA_W;

   logic              push_valid;
   logic              push_ready;
   cmd_flags_type     push_flags;
   logic [DATA_W-1:0] push_data;
   logic              pop_valid;
   logic              pop_ready;
   logic [Q_W-1:0]    pop_entry;
   cmd_flags_type     pop_flags;

   // Classification of incoming transfers.
   alsp_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_flags (push_flags),
      .push_data  (push_data)
   );

   // Commands waiting for the back end.
   alsp_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_flags, push_data}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_entry)
   );

   assign pop_flags = cmd_flags_type'(pop_entry[Q_W-1 -: CMD_FLAG_BITS]);

   // Line setup, slope division and column generation.
   alsp_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_flags (pop_flags),
      .pop_data  (pop_entry[DATA_W-1:0]),
      .rsp_ch    (rsp_ch)
   );

endmodule
`default_nettype wire

/* hw/rtl/alsp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line stepper response checker
// Watches the top level response channel: handshake and result contents.
// ----------------------------------------------------------------------------
module alsp_checker
   import alsp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic                  rsp_accepted,
   input wire logic                  rsp_pixel_valid,
   input wire logic [COORD_BITS-1:0] rsp_first_x,
   input wire logic [COORD_BITS-1:0] rsp_first_y,
   input wire logic [COORD_BITS-1:0] rsp_second_x,
   input wire logic [COORD_BITS-1:0] rsp_second_y,
   input wire logic [FRAC_BITS:0]    rsp_weight_first,
   input wire logic [FRAC_BITS-1:0]  rsp_weight_second,
   input wire logic                  rsp_reversed,
   input wire logic                  rsp_last
);

   // No result is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stall holds valid, first_x/y, weight_first, last, reversed and accepted.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_first_x) &&
      $stable(rsp_first_y) && $stable(rsp_weight_first) && $stable(rsp_last) &&
      $stable(rsp_reversed) && $stable(rsp_accepted))
      else $error("stalled response changed");

   // A pixel pair's two coverage weights add up to one and accepted is low.
   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixel_valid |->
      ((FRAC_BITS + 1)'(rsp_weight_first + {1'b0, rsp_weight_second}) ==
       {1'b1, {FRAC_BITS{1'b0}}}) && !rsp_accepted)
      else $error("pixel weights do not sum to one");

   // A result without pixels carries no coordinates, weights or last mark.
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pixel_valid |->
      rsp_first_x == '0 && rsp_first_y == '0 && rsp_second_x == '0 &&
      rsp_second_y == '0 && rsp_weight_first == '0 && rsp_weight_second == '0 &&
      !rsp_last)
      else $error("non-pixel response carries pixel data");

endmodule

bind antialiased_line_stepper_top alsp_checker #(
   .COORD_BITS (COORD_BITS),
   .FRAC_BITS  (FRAC_BITS)
) u_alsp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_accepted      (rsp_ch.accepted),
   .rsp_pixel_valid   (rsp_ch.pixel_valid),
   .rsp_first_x       (rsp_ch.first_x),
   .rsp_first_y       (rsp_ch.first_y),
   .rsp_second_x      (rsp_ch.second_x),
   .rsp_second_y      (rsp_ch.second_y),
   .rsp_weight_first  (rsp_ch.weight_first),
   .rsp_weight_second (rsp_ch.weight_second),
   .rsp_reversed      (rsp_ch.reversed),
   .rsp_last          (rsp_ch.last)
);
`default_nettype wire
